// ===== hdl/luma_overlay_blend_defines.svh =====
// Assertion macros shared by the luma overlay blend checker.
`ifndef LUMA_OVERLAY_BLEND_DEFINES_SVH
`define LUMA_OVERLAY_BLEND_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LOB_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("luma overlay blend check failed");

// Next-cycle implication, checked outside reset.
`define LOB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("luma overlay blend check failed");

// Property checked at every edge, reset included.
`define LOB_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge aclk) (prop)) \
        else $error("luma overlay blend check failed");

`endif

// ===== hdl/lob_pkg.sv =====
// Types and constants shared by the luma overlay blend and its checker.
package lob_pkg;

    localparam int unsigned CHAN_W = 8;
    localparam int unsigned K_W    = 9;
    localparam int unsigned IDX_W  = 1;

    // Register indexes
    localparam logic [IDX_W-1:0] REG_INTENSITY   = 1'd0;
    localparam logic [IDX_W-1:0] REG_SINGLE_MODE = 1'd1;

    localparam logic [K_W-1:0] INTENSITY_RESET = 9'd205;
    localparam logic [K_W-1:0] INTENSITY_FULL  = 9'd256;

    // Luma weights, Q0.8
    localparam logic [7:0] LUMA_R = 8'd77;
    localparam logic [7:0] LUMA_G = 8'd150;
    localparam logic [7:0] LUMA_B = 8'd29;

    typedef struct packed {
        logic [CHAN_W-1:0] base_red;
        logic [CHAN_W-1:0] base_green;
        logic [CHAN_W-1:0] base_blue;
        logic [CHAN_W-1:0] over_red;
        logic [CHAN_W-1:0] over_green;
        logic [CHAN_W-1:0] over_blue;
    } in_item_t;

    typedef struct packed {
        logic [CHAN_W-1:0] out_red;
        logic [CHAN_W-1:0] out_green;
        logic [CHAN_W-1:0] out_blue;
    } out_item_t;

endpackage

// ===== hdl/luma_overlay_blend.sv =====
// Luma overlay blend: four-stage pipeline, overlay blend mode mixed by intensity.
//
//   channel | direction | handshake            | payload
//   s_      | in        | s_valid / s_ready    | s_data  (lob_pkg::in_item_t)
//   m_      | out       | m_valid / m_ready    | m_data  (lob_pkg::out_item_t)
//   cfg_    | in        | cfg_wr_en            | cfg_index, cfg_wdata
//
// One pixel per clock while m_ready does not stall; m_valid is the valid bit of the output register.
// Stages: luma, blend product, divide by 255, intensity mix into the output register.
// Each stage loads when it is empty or its successor moves, so bubbles close up
// and a stall on m_ready holds every item that has no empty stage ahead of it.
// Synchronous active-low reset clears the valid bits and restores the configuration registers.
module luma_overlay_blend (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [lob_pkg::IDX_W-1:0]   cfg_index,
    input  logic [lob_pkg::K_W-1:0]     cfg_wdata,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  lob_pkg::in_item_t           s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output lob_pkg::out_item_t          m_data
);

    // x / 255 for x below 65280, so that the quotient fits eight bits: reciprocal multiply, then one correction step
    function automatic logic [7:0] div255(input logic [16:0] p);
        logic [25:0] prod;
        logic [9:0]  q;
        logic [17:0] rem;
        prod = 26'(p) * 26'd257;
        q    = prod[25:16];
        rem  = 18'(p) - 18'(q) * 18'd255;
        if (rem >= 18'd255) begin
            q = q + 10'd1;
        end
        return q[7:0];
    endfunction

    // b + (o - b) * k / 256, clamped to the channel range
    function automatic logic [7:0] mix(input logic [7:0] b, input logic [7:0] o,
                                       input logic [8:0] k);
        logic signed [9:0]  d;
        logic signed [19:0] prod;
        logic signed [20:0] sum;
        logic [7:0]         res;
        d    = $signed({2'b00, o}) - $signed({2'b00, b});
        prod = 20'(d) * 20'($signed({1'b0, k}));
        sum  = $signed({5'b00000, b, 8'h00}) + 21'(prod);
        if (sum[20]) begin
            res = 8'd0;
        end else if (sum[19:8] > 12'd255) begin
            res = 8'd255;
        end else begin
            res = sum[15:8];
        end
        return res;
    endfunction

    // Configuration registers
    logic [lob_pkg::K_W-1:0] intensity_reg;
    logic                    single_mode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            intensity_reg   <= lob_pkg::INTENSITY_RESET;
            single_mode_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                lob_pkg::REG_INTENSITY:   intensity_reg   <= cfg_wdata;
                lob_pkg::REG_SINGLE_MODE: single_mode_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Pipeline registers
    logic                    v1_reg, v2_reg, v3_reg, v4_reg;
    logic [2:0][7:0]         base1_reg, base2_reg, base3_reg;
    logic [7:0]              lum1_reg;
    logic [lob_pkg::K_W-1:0] k1_reg, k2_reg, k3_reg;
    logic [2:0]              dark2_reg;
    logic [2:0][16:0]        prod2_reg;
    logic [2:0][7:0]         blend3_reg;
    lob_pkg::out_item_t      out4_reg;

    // Stage load enables, back to front
    logic ld1, ld2, ld3, ld4;
    assign ld4 = !v4_reg || m_ready;
    assign ld3 = !v3_reg || ld4;
    assign ld2 = !v2_reg || ld3;
    assign ld1 = !v1_reg || ld2;
    assign s_ready = ld1;

    // Stage 1 logic: luminance (the overlay red channel in single mode) and saturated intensity
    logic [15:0]             luma_sum;
    logic [7:0]              lum_next;
    logic [lob_pkg::K_W-1:0] k_next;

    always_comb begin
        luma_sum = 16'(lob_pkg::LUMA_R) * 16'(s_data.over_red)
                 + 16'(lob_pkg::LUMA_G) * 16'(s_data.over_green)
                 + 16'(lob_pkg::LUMA_B) * 16'(s_data.over_blue);
        lum_next = single_mode_reg ? s_data.over_red : luma_sum[15:8];
        k_next   = (intensity_reg > lob_pkg::INTENSITY_FULL) ? lob_pkg::INTENSITY_FULL
                                                             : intensity_reg;
    end

    // Stage 2 logic: doubled product, dark or light branch
    logic [2:0]       dark_next;
    logic [2:0][16:0] prod_next;
    logic [7:0]       fa, fl;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            dark_next[i] = !base1_reg[i][7];
            fa = dark_next[i] ? base1_reg[i] : 8'd255 - base1_reg[i];
            fl = dark_next[i] ? lum1_reg : 8'd255 - lum1_reg;
            prod_next[i] = {16'(fa) * 16'(fl), 1'b0};
        end
    end

    // Stage 3 logic: divide by 255 and fold the light branch
    logic [2:0][7:0] blend_next;
    logic [7:0]      quo;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            quo = div255(prod2_reg[i]);
            blend_next[i] = dark2_reg[i] ? quo : 8'd255 - quo;
        end
    end

    // Stage 4 logic: intensity mix
    lob_pkg::out_item_t out_next;

    always_comb begin
        out_next.out_red   = mix(base3_reg[2], blend3_reg[2], k3_reg);
        out_next.out_green = mix(base3_reg[1], blend3_reg[1], k3_reg);
        out_next.out_blue  = mix(base3_reg[0], blend3_reg[0], k3_reg);
    end

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (ld1) v1_reg <= s_valid;
            if (ld2) v2_reg <= v1_reg;
            if (ld3) v3_reg <= v2_reg;
            if (ld4) v4_reg <= v3_reg;
        end
    end

    // Payload stages
    always_ff @(posedge aclk) begin
        if (ld1) begin
            base1_reg <= {s_data.base_red, s_data.base_green, s_data.base_blue};
            lum1_reg  <= lum_next;
            k1_reg    <= k_next;
        end
        if (ld2) begin
            base2_reg <= base1_reg;
            k2_reg    <= k1_reg;
            dark2_reg <= dark_next;
            prod2_reg <= prod_next;
        end
        if (ld3) begin
            base3_reg  <= base2_reg;
            k3_reg     <= k2_reg;
            blend3_reg <= blend_next;
        end
        if (ld4) begin
            out4_reg <= out_next;
        end
    end

    assign m_valid = v4_reg;
    assign m_data  = out4_reg;

endmodule

// ===== hdl/lob_checker.sv =====
// Port-level checks for the luma overlay blend, bound to the top level.
`include "luma_overlay_blend_defines.svh"

module lob_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input lob_pkg::out_item_t m_data
);

    // A stalled result holds its value
    `LOB_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data))

    // An empty output register means the whole pipeline can take a pixel
    `LOB_ASSERT_IMP(a_ready_when_drained, !m_valid, s_ready)

    // A refused input transfer only happens behind a stalled result
    `LOB_ASSERT_IMP(a_input_stall, s_valid && !s_ready, m_valid && !m_ready)

    // Nothing comes out in the cycle after reset
    `LOB_ASSERT_ALWAYS(a_reset_clears, $past(!aresetn) |-> !m_valid)

endmodule

bind luma_overlay_blend lob_checker u_lob_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
